// ----- rtl/prt_pkg.sv -----
package prt_pkg;

  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;
  localparam int CMD_W    = 2;

  // APB: one 32-bit register at byte address 0; bit 2 selects the register.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TIMEOUT = '0;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAN  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEANED  = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   client_id;
    logic [ID_W-1:0]   requester_tag;
    logic [ID_W-1:0]   lookup_id;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned_id;
    logic [ID_W-1:0]     found_client_id;
    logic [ID_W-1:0]     found_requester;
    logic [COUNT_W-1:0]  removed_count;
  } rsp_t;

endpackage

// ----- rtl/pending_request_table.sv -----
// Pending request table: tracks outstanding forwarded requests by a 16-bit
// transaction id. Each command (insert, lookup-and-remove, clean) is taken
// into an input register and executed from there against all slots at once
// when the output register is empty or being drained, so one command per
// cycle is sustained while responses are accepted; the result then goes into
// the output register. The id and age compares run in parallel across the table.
// The input register keeps taking transfers while the output register is
// empty or being drained; both stall only when a result waits unaccepted
// and the next command is already staged. Command value 3 is
// consumed without a response. The timeout register (APB, byte address 0,
// reset value 10) must only be written while the block is idle.
module pending_request_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prt_pkg::PADDR_W-1:0]  paddr,
  input  logic [prt_pkg::PDATA_W-1:0]  pwdata,
  output logic [prt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  prt_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output prt_pkg::rsp_t                rsp
);
  import prt_pkg::*;

  logic             stage_valid;
  req_t             stage;
  logic             exec;
  logic [TMO_W-1:0] timeout_seconds;
  rsp_t             result;
  logic             has_result;

  assign exec      = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || exec;

  prt_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .timeout_seconds (timeout_seconds)
  );

  prt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk             (clk),
    .rst             (rst),
    .exec            (exec),
    .op              (stage),
    .timeout_seconds (timeout_seconds),
    .result          (result),
    .has_result      (has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec && has_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && has_result) begin
      rsp <= result;
    end
  end

endmodule

// ----- rtl/prt_regs.sv -----
module prt_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prt_pkg::PADDR_W-1:0]  paddr,
  input  logic [prt_pkg::PDATA_W-1:0]  pwdata,
  output logic [prt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [prt_pkg::TMO_W-1:0]    timeout_seconds
);
  import prt_pkg::*;

  logic sel_timeout;

  assign sel_timeout = (paddr[PADDR_W-1:2] == REG_TIMEOUT);
  assign pready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && sel_timeout) begin
      timeout_seconds <= pwdata[TMO_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_timeout) begin
      prdata = {{(PDATA_W-TMO_W){1'b0}}, timeout_seconds};
    end
  end

endmodule

// ----- rtl/prt_table.sv -----
module prt_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       exec,
  input  prt_pkg::req_t              op,
  input  logic [prt_pkg::TMO_W-1:0]  timeout_seconds,
  output prt_pkg::rsp_t              result,
  output logic                       has_result
);
  import prt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [ID_W-1:0]        slot_id        [TABLE_DEPTH];
  logic [ID_W-1:0]        slot_client    [TABLE_DEPTH];
  logic [ID_W-1:0]        slot_requester [TABLE_DEPTH];
  logic [TIME_W-1:0]      slot_time      [TABLE_DEPTH];
  logic [ID_W-1:0]        next_id;

  logic [TABLE_DEPTH-1:0] dup_hit, look_hit, expire;
  logic                   dup_any, free_any, look_any, ins_any;
  logic [IDX_W-1:0]       dup_idx, free_idx, look_idx, ins_idx;
  logic [CNT_W-1:0]       exp_cnt;
  logic [CNT_W+5:0]       exp_cnt_ext;

  // Every slot has its own id and age comparators.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      dup_hit[i]  = slot_valid[i] && (slot_id[i] == next_id);
      look_hit[i] = slot_valid[i] && (slot_id[i] == op.lookup_id);
      expire[i]   = slot_valid[i] &&
                    (({1'b0, slot_time[i]} + {{(TIME_W-TMO_W+1){1'b0}}, timeout_seconds})
                     < {1'b0, op.now});
    end
  end

  // Priority encoders; walking downward leaves the lowest index.
  always_comb begin
    dup_any  = 1'b0;
    dup_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    look_any = 1'b0;
    look_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (dup_hit[i]) begin
        dup_any = 1'b1;
        dup_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (look_hit[i]) begin
        look_any = 1'b1;
        look_idx = IDX_W'(i);
      end
    end
  end

  assign ins_any     = dup_any || free_any;
  assign ins_idx     = dup_any ? dup_idx : free_idx;
  assign exp_cnt     = CNT_W'($countones(expire));
  assign exp_cnt_ext = (CNT_W+6)'(exp_cnt);

  always_comb begin
    result     = '0;
    has_result = 1'b1;
    case (op.command)
      CMD_INSERT: begin
        if (ins_any) begin
          result.status      = ST_INSERTED;
          result.assigned_id = next_id;
        end else begin
          result.status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (look_any) begin
          result.status          = ST_FOUND;
          result.assigned_id     = op.lookup_id;
          result.found_client_id = slot_client[look_idx];
          result.found_requester = slot_requester[look_idx];
        end else begin
          result.status = ST_MISSING;
        end
      end
      CMD_CLEAN: begin
        result.status = ST_CLEANED;
        if (exp_cnt_ext > (CNT_W+6)'(COUNT_MAX)) begin
          result.removed_count = COUNT_MAX;
        end else begin
          result.removed_count = exp_cnt_ext[COUNT_W-1:0];
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      next_id    <= '0;
    end else if (exec) begin
      case (op.command)
        CMD_INSERT: begin
          if (ins_any) begin
            slot_valid[ins_idx] <= 1'b1;
            next_id             <= next_id + 16'd1;
          end
        end
        CMD_LOOKUP: begin
          if (look_any) begin
            slot_valid[look_idx] <= 1'b0;
          end
        end
        CMD_CLEAN: begin
          slot_valid <= slot_valid & ~expire;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec && (op.command == CMD_INSERT) && ins_any) begin
      slot_id[ins_idx]        <= next_id;
      slot_client[ins_idx]    <= op.client_id;
      slot_requester[ins_idx] <= op.requester_tag;
      slot_time[ins_idx]      <= op.now;
    end
  end

  a_lookup_frees: assert property (@(posedge clk) disable iff (rst)
    exec && (op.command == CMD_LOOKUP) && look_any |=> !slot_valid[$past(look_idx)])
    else $error("matched slot still live after lookup");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    exec && (op.command == CMD_INSERT) && !ins_any |-> (&slot_valid))
    else $error("insert reported full with a free slot");

  a_clean_count: assert property (@(posedge clk) disable iff (rst)
    exec && (op.command == CMD_CLEAN) |=>
      ($countones(slot_valid) + $past(int'(exp_cnt))) == $past($countones(slot_valid)))
    else $error("clean count disagrees with slots removed");

endmodule
